>>> rtl/rrq_pkg.sv
// rrq_pkg: shared types and codes for the round-robin run queue
// request and result payloads, opcodes, status codes, sequencer states
// no dependencies
package rrq_pkg;

  typedef struct packed {
    logic [2:0] opcode;
    logic [6:0] task_id;
  } rrq_cmd_t;

  typedef struct packed {
    logic [6:0] running_id;
    logic       switched;
    logic [6:0] new_id;
    logic [1:0] status;
  } rrq_res_t;

  typedef enum logic [2:0] {
    OP_TICK         = 3'd0,
    OP_SWITCH_SLEEP = 3'd1,
    OP_SLEEP        = 3'd2,
    OP_WAKEUP       = 3'd3,
    OP_NEW_TASK     = 3'd4
  } rrq_op_t;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NO_TASK    = 2'd1;
  localparam logic [1:0] ST_TABLE_FULL = 2'd2;
  localparam logic [1:0] ST_WOULD_EMPTY = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_WALK,
    S_DONE
  } rrq_state_t;

endpackage

>>> rtl/rrq_ram.sv
// rrq_ram: ring storage for the queued ids behind the running task
// one write port, one registered read port; uses no package
module rrq_ram #(
  parameter int MAX_TASKS = 64
) (
  input  logic                   clk,
  input  logic                   we,
  input  logic [$clog2(((MAX_TASKS < 127) ? MAX_TASKS : 127))-1:0] waddr,
  input  logic [6:0]             wdata,
  input  logic [$clog2(((MAX_TASKS < 127) ? MAX_TASKS : 127))-1:0] raddr,
  output logic [6:0]             rdata
);

  localparam int DEPTH = (MAX_TASKS < 127) ? MAX_TASKS : 127;

  logic [6:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/rrq_seq.sv
// rrq_seq: scheduler sequencer, head register, ring pointers and membership flags
// depends on rrq_pkg; drives the ring storage in rrq_ram
module rrq_seq #(
  parameter int MAX_TASKS = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  rrq_pkg::rrq_cmd_t cmd,
  output logic              idle,
  output logic              done,
  output rrq_pkg::rrq_res_t res,
  input  logic              take,
  output logic              ram_we,
  output logic [$clog2(((MAX_TASKS < 127) ? MAX_TASKS : 127))-1:0] ram_waddr,
  output logic [6:0]        ram_wdata,
  output logic [$clog2(((MAX_TASKS < 127) ? MAX_TASKS : 127))-1:0] ram_raddr,
  input  logic [6:0]        ram_rdata
);
  import rrq_pkg::*;

  localparam int FLAG_N = (MAX_TASKS < 127) ? MAX_TASKS : 127;
  localparam int FLAG_W = $clog2(FLAG_N);
  localparam int PTR_W  = FLAG_W;
  localparam int CNT_W  = $clog2(FLAG_N + 1);
  localparam int LI_W   = $clog2(MAX_TASKS + 1);
  localparam int CMP_W  = (LI_W > 7) ? LI_W : 7;

  rrq_state_t        state, state_next;
  logic [6:0]        head, head_next;
  logic [PTR_W-1:0]  rd_ptr, rd_ptr_next;
  logic [PTR_W-1:0]  wr_ptr, wr_ptr_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [CNT_W-1:0]  walk_left, walk_left_next;
  logic [LI_W-1:0]   last, last_next;
  logic [FLAG_N-1:0] flags, flags_next;
  logic [6:0]        target, target_next;
  logic              pop_drop, pop_drop_next;
  rrq_res_t          res_q, res_next;

  logic [6:0]        cmd_m1, head_m1;
  logic [FLAG_W-1:0] cmd_idx, head_idx;
  logic              known, flag_hit, is_head, multi;
  logic [LI_W-1:0]   last_inc;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(FLAG_N - 1)) ? '0 : p + 1'b1;
  endfunction

  assign cmd_m1   = cmd.task_id - 7'd1;
  assign head_m1  = head - 7'd1;
  assign cmd_idx  = FLAG_W'(cmd_m1);
  assign head_idx = FLAG_W'(head_m1);
  // ids above the last issued one (or zero) are unknown
  assign known    = (cmd.task_id != 7'd0) && (CMP_W'(cmd.task_id) <= CMP_W'(last));
  assign flag_hit = known && flags[cmd_idx];
  assign is_head  = (cmd.task_id == head);
  assign multi    = (count != CNT_W'(1));
  assign last_inc = last + 1'b1;

  assign ram_raddr = rd_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= 7'd1;
      rd_ptr    <= '0;
      wr_ptr    <= '0;
      count     <= CNT_W'(1);
      walk_left <= '0;
      last      <= LI_W'(1);
      flags     <= FLAG_N'(1);
    end else begin
      state     <= state_next;
      head      <= head_next;
      rd_ptr    <= rd_ptr_next;
      wr_ptr    <= wr_ptr_next;
      count     <= count_next;
      walk_left <= walk_left_next;
      last      <= last_next;
      flags     <= flags_next;
    end
  end

  always_ff @(posedge clk) begin
    target   <= target_next;
    pop_drop <= pop_drop_next;
    res_q    <= res_next;
  end

  always_comb begin
    state_next     = state;
    head_next      = head;
    rd_ptr_next    = rd_ptr;
    wr_ptr_next    = wr_ptr;
    count_next     = count;
    walk_left_next = walk_left;
    last_next      = last;
    flags_next     = flags;
    target_next    = target;
    pop_drop_next  = pop_drop;
    res_next       = res_q;
    ram_we         = 1'b0;
    ram_waddr      = wr_ptr;
    ram_wdata      = head;
    case (state)
      S_IDLE: begin
        if (start) begin
          res_next   = '{running_id: head, switched: 1'b0, new_id: 7'd0, status: ST_OK};
          state_next = S_DONE;
          case (cmd.opcode)
            OP_TICK: begin
              if (multi) begin
                pop_drop_next = 1'b0;
                state_next    = S_POP;
              end
            end
            OP_SWITCH_SLEEP: begin
              if (multi) begin
                pop_drop_next = 1'b1;
                state_next    = S_POP;
              end else begin
                res_next.status = ST_WOULD_EMPTY;
              end
            end
            OP_SLEEP: begin
              if (!known) begin
                res_next.status = ST_NO_TASK;
              end else if (flag_hit) begin
                if (is_head) begin
                  if (multi) begin
                    pop_drop_next = 1'b1;
                    state_next    = S_POP;
                  end else begin
                    res_next.status = ST_WOULD_EMPTY;
                  end
                end else begin
                  // id sits behind the head: rewrite the ring without it
                  flags_next[cmd_idx] = 1'b0;
                  count_next          = count - 1'b1;
                  target_next         = cmd.task_id;
                  walk_left_next      = count - CNT_W'(2);
                  rd_ptr_next         = ptr_inc(rd_ptr);
                  state_next          = S_WALK;
                end
              end
            end
            OP_WAKEUP: begin
              if (!known) begin
                res_next.status = ST_NO_TASK;
              end else if (!flag_hit && (count < CNT_W'(FLAG_N))) begin
                ram_we              = 1'b1;
                ram_wdata           = cmd.task_id;
                wr_ptr_next         = ptr_inc(wr_ptr);
                count_next          = count + 1'b1;
                flags_next[cmd_idx] = 1'b1;
              end
            end
            OP_NEW_TASK: begin
              if (last >= LI_W'(MAX_TASKS)) begin
                res_next.status = ST_TABLE_FULL;
              end else begin
                last_next       = last_inc;
                res_next.new_id = 7'(last_inc);
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_POP: begin
        // ring front arrives, becomes the new head
        head_next           = ram_rdata;
        rd_ptr_next         = ptr_inc(rd_ptr);
        res_next.running_id = ram_rdata;
        res_next.switched   = 1'b1;
        if (pop_drop) begin
          flags_next[head_idx] = 1'b0;
          count_next           = count - 1'b1;
        end else begin
          ram_we      = 1'b1;
          ram_wdata   = head;
          wr_ptr_next = ptr_inc(wr_ptr);
        end
        state_next = S_DONE;
      end
      S_WALK: begin
        if (ram_rdata != target) begin
          ram_we      = 1'b1;
          ram_wdata   = ram_rdata;
          wr_ptr_next = ptr_inc(wr_ptr);
        end
        if (walk_left != '0) begin
          rd_ptr_next    = ptr_inc(rd_ptr);
          walk_left_next = walk_left - 1'b1;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (take) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign idle = (state == S_IDLE);
  assign done = (state == S_DONE);
  assign res  = res_q;

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    count != '0)
    else $error("run queue count reached zero");

  a_count_flags: assert property (@(posedge clk) disable iff (rst)
    $countones(flags) == int'(count))
    else $error("membership flags disagree with queue count");

  a_head_flagged: assert property (@(posedge clk) disable iff (rst)
    idle |-> flags[head_idx])
    else $error("running task not marked as queued");

  a_walk_steps: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) && (walk_left != '0) |=>
      (state == S_WALK) && (walk_left == $past(walk_left) - 1'b1))
    else $error("ring walk skipped a step");

  a_switch_ok: assert property (@(posedge clk) disable iff (rst)
    done && res_q.switched |-> (res_q.status == ST_OK))
    else $error("switch reported with error status");

endmodule

>>> rtl/round_robin_run_queue.sv
// round_robin_run_queue: top level of the round-robin task run queue
// depends on rrq_pkg, rrq_seq and rrq_ram
//
// Hardware run queue of task ids, handled one request at a time. The running
// task is held in a head register; the ids queued behind it live in a ring
// memory of min(MAX_TASKS, 127) entries with one write and one registered read
// port. After reset only the main task (id 1) is queued and the ring is empty;
// the memory needs no clearing pass. A new task, a wakeup, an unknown id or a
// refused request is answered without a ring read; a tick or a switch that
// drops the head first reads the ring once. A sleep of an id queued behind
// the head rewrites the ring through the single read port, one entry per cycle.
// cmd_ready is high only while the sequencer is idle; the result sits in an
// output register, so a new request can be taken while the previous result
// still waits on res_ready.
module round_robin_run_queue #(
  parameter int MAX_TASKS = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  rrq_pkg::rrq_cmd_t cmd,
  output logic              res_valid,
  input  logic              res_ready,
  output rrq_pkg::rrq_res_t res
);
  import rrq_pkg::*;

  localparam int RING_N = (MAX_TASKS < 127) ? MAX_TASKS : 127;
  localparam int PTR_W  = $clog2(RING_N);

  logic             start;
  logic             seq_idle;
  logic             seq_done;
  logic             seq_take;
  rrq_res_t         seq_res;
  logic             ram_we;
  logic [PTR_W-1:0] ram_waddr;
  logic [6:0]       ram_wdata;
  logic [PTR_W-1:0] ram_raddr;
  logic [6:0]       ram_rdata;
  rrq_res_t         res_q;

  // request taken whenever the sequencer is idle
  assign cmd_ready = seq_idle;
  assign start     = cmd_valid && cmd_ready;

  // move the finished result into the output register once it is free
  assign seq_take = seq_done && (!res_valid || res_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (seq_take) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  // payload register, loaded only with a fresh result
  always_ff @(posedge clk) begin
    if (seq_take) begin
      res_q <= seq_res;
    end
  end

  assign res = res_q;

  // sequencer: head, pointers, flags, counters and the compare unit
  rrq_seq #(
    .MAX_TASKS(MAX_TASKS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cmd       (cmd),
    .idle      (seq_idle),
    .done      (seq_done),
    .res       (seq_res),
    .take      (seq_take),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  // ring of ids waiting behind the running task
  rrq_ram #(
    .MAX_TASKS(MAX_TASKS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule
